FILE: src/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// Shared types and constants for the direct-form FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  // fixed field widths
  localparam int ACC_W  = 38;
  localparam int TAPS_W = 7;
  localparam int IDX_W  = 6;
  localparam int ACT_W  = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FILTER = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

FILE: src/fir_filter_direct_form_top.sv
// filter sample: result registered after the S_RUN tap walk, S_DRAIN and S_DONE, one MAC per tap
// load and push items: taken in S_IDLE, no result
// next item is taken when the result appears; the shared multiplier sets the rate
// reset: sequencer idle, output empty, active_taps = 1, coefficients and history read zero
// ----------------------------------------------------------------------------
// fir_filter_direct_form_top
// Direct-form FIR filter built around one shared multiply-accumulate unit that
// walks the coefficient store and the circular history line one tap a cycle.
// ----------------------------------------------------------------------------
module fir_filter_direct_form_top #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fir_pkg::TAPS_W-1:0]        cfg_data,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fir_pkg::ACT_W-1:0]         action,
  input  logic [fir_pkg::IDX_W-1:0]         coeff_index,
  input  logic signed [COEFF_BITS-1:0]      coeff_value,
  input  logic signed [SAMPLE_BITS-1:0]     sample_value,
  input  logic                              end_of_block,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fir_pkg::ACC_W-1:0]  filtered_value,
  output logic                              block_end
);

  import fir_pkg::*;

  localparam int HIST_DEPTH = MAX_TAPS - 1;
  localparam int CAW        = $clog2(MAX_TAPS);
  localparam int HAW        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int TCW        = $clog2(MAX_TAPS + 1);
  localparam int PW         = COEFF_BITS + SAMPLE_BITS;

  state_t state, state_next;

  logic [TAPS_W-1:0]              active_taps;
  logic [TCW-1:0]                 taps_eff;
  logic [TCW-1:0]                 ntaps;
  logic [TCW-1:0]                 iss_cnt;
  logic [HAW-1:0]                 wp;
  logic [HAW-1:0]                 rd_pos;
  logic signed [SAMPLE_BITS-1:0]  x_reg;
  logic                           eob_reg;

  logic in_fire, load_ok, push_now, start, issue, finish;
  logic [CAW-1:0]                 caddr_w;

  // storage
  logic signed [COEFF_BITS-1:0]   cmem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0]  hmem [HIST_DEPTH];
  logic [MAX_TAPS-1:0]            cvld;
  logic [HIST_DEPTH-1:0]          hvld;
  logic                           hw_en;
  logic signed [SAMPLE_BITS-1:0]  hw_data;

  // mac pipeline
  logic                           s1_v, s1_first, c_ok, h_ok;
  logic signed [COEFF_BITS-1:0]   c_rd, coef_op;
  logic signed [SAMPLE_BITS-1:0]  h_rd, samp_op;
  logic                           s2_v;
  logic signed [PW-1:0]           prod;
  logic [ACC_W-1:0]               acc;

  // config writes are taken whenever out of reset
  assign cfg_ready = !rst;

  // transfer decode
  assign in_fire  = in_valid && in_ready;
  assign load_ok  = in_fire && (action == ACT_LOAD) && (32'(coeff_index) < MAX_TAPS);
  assign push_now = in_fire && (action == ACT_PUSH);
  assign start    = in_fire && (action == ACT_FILTER);
  assign caddr_w  = CAW'(coeff_index);

  // effective tap count, saturated to 1..MAX_TAPS
  always_comb begin
    if (active_taps == '0) begin
      taps_eff = TCW'(1);
    end else if (32'(active_taps) > MAX_TAPS) begin
      taps_eff = TCW'(MAX_TAPS);
    end else begin
      taps_eff = TCW'(active_taps);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && (action == ACT_FILTER)) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        issue = 1'b1;
        if (iss_cnt == ntaps - TCW'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_v && !s2_v) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps <= TAPS_W'(1);
      wp          <= '0;
      cvld        <= '0;
      hvld        <= '0;
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_taps <= cfg_data;
      end
      if (load_ok) begin
        cvld[caddr_w] <= 1'b1;
      end
      if (hw_en) begin
        hvld[wp] <= 1'b1;
        wp       <= (wp == HAW'(HIST_DEPTH - 1)) ? '0 : wp + HAW'(1);
      end
      s1_v <= issue;
      s2_v <= s1_v;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // per-item registers and tap walk
  always_ff @(posedge clk) begin
    if (start) begin
      x_reg   <= sample_value;
      eob_reg <= end_of_block;
      ntaps   <= taps_eff;
      iss_cnt <= '0;
      rd_pos  <= (wp == '0) ? HAW'(HIST_DEPTH - 1) : wp - HAW'(1);
    end else if (issue) begin
      iss_cnt <= iss_cnt + TCW'(1);
      if (iss_cnt != '0) begin
        rd_pos <= (rd_pos == '0) ? HAW'(HIST_DEPTH - 1) : rd_pos - HAW'(1);
      end
    end
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (load_ok) begin
      cmem[caddr_w] <= coeff_value;
    end
    if (issue) begin
      c_rd <= cmem[iss_cnt[CAW-1:0]];
    end
  end

  // history line, written by pushes and at the end of a filter item
  assign hw_en   = push_now || finish;
  assign hw_data = push_now ? sample_value : x_reg;

  always_ff @(posedge clk) begin
    if (hw_en) begin
      hmem[wp] <= hw_data;
    end
    if (issue) begin
      h_rd <= hmem[rd_pos];
    end
  end

  // read stage flags
  always_ff @(posedge clk) begin
    if (issue) begin
      c_ok     <= cvld[iss_cnt[CAW-1:0]];
      h_ok     <= hvld[rd_pos];
      s1_first <= (iss_cnt == '0);
    end
  end

  // operand select: unwritten entries read zero, tap zero uses the new sample
  assign coef_op = c_ok ? c_rd : '0;
  assign samp_op = s1_first ? x_reg : (h_ok ? h_rd : '0);

  // multiply stage
  always_ff @(posedge clk) begin
    if (s1_v) begin
      prod <= coef_op * samp_op;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (finish) begin
      filtered_value <= acc;
      block_end      <= eob_reg;
    end
  end

endmodule

FILE: src/fir_chk.sv
// ----------------------------------------------------------------------------
// fir_chk
// Port-level checks for the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module fir_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [fir_pkg::ACT_W-1:0]         action,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [fir_pkg::ACC_W-1:0]  filtered_value,
  input logic                              block_end
);

  import fir_pkg::*;

  // a waiting result holds until its transfer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value) && $stable(block_end))
    else $error("result changed while stalled");

  // a filter sample occupies the mac, so the input closes
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_FILTER) |=> !in_ready)
    else $error("input open while filtering");

  // loads and pushes make no result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action != ACT_FILTER) |=> !$rose(out_valid))
    else $error("result after non-filter item");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fir_filter_direct_form_top fir_chk u_fir_chk (.*);
